// ===== sv/hcs_pkg.sv =====
// Shared types and constants for the Hamiltonian circuit search block.
// Depends on nothing; the top level and the checker import it.
package hcs_pkg;

   // Default graph size; the top level takes it as a parameter.
   localparam int NUM_VERTICES_DEF = 8;

   // Fixed field widths of the request and response transactions.
   localparam int ROW_INDEX_W = 3;
   localparam int ROW_BITS_W  = 8;
   localparam int VERTEX_W    = 3;

   // Request command codes.
   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [ROW_INDEX_W-1:0] row_index;
      logic [ROW_BITS_W-1:0]  row_bits;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [VERTEX_W-1:0] vertex;
      logic                last;
   } rsp_type;

endpackage

// ===== sv/hcs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module hcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register one read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hcs_adj_store.sv =====
// Adjacency matrix store: one row per source vertex in a RAM, with per-row
// valid flops so that unwritten rows read as zero after reset. Uses hcs_ram.
module hcs_adj_store #(
   parameter int NUM_VERTICES = 8,
   localparam int VW = $clog2(NUM_VERTICES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [VW-1:0]           wr_addr,
   input  logic [NUM_VERTICES-1:0] wr_row,
   input  logic [VW-1:0]           rd_addr,
   output logic [NUM_VERTICES-1:0] rd_row
);

   logic [NUM_VERTICES-1:0] valid_ff;
   logic [NUM_VERTICES-1:0] valid_in;
   logic                    rd_valid_ff;
   logic [NUM_VERTICES-1:0] ram_row;

   hcs_ram #(
      .WIDTH (NUM_VERTICES),
      .DEPTH (NUM_VERTICES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (1'b1),
      .rd_addr (rd_addr),
      .rd_data (ram_row)
   );

   // Mark a row valid once written.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // Clear valid flags at reset; track validity of the row being read.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Drop data of rows never written.
   assign rd_row = rd_valid_ff ? ram_row : '0;

endmodule

// ===== sv/hamiltonian_circuit_search.sv =====
// Hamiltonian circuit search: a row load / search command port and a result
// strobe port. The adjacency matrix sits in hcs_adj_store, the path stack in
// an hcs_ram; a small sequencer walks the depth-first backtracking.
//
// Usage:
//  - A request transaction is taken when start is high and busy is low.
//    cmd = CMD_LOAD writes adjacency row row_index (rows at or beyond the
//    graph size are ignored, bits beyond it dropped); it gives no result
//    and leaves busy low, so loads can follow back to back.
//  - cmd = CMD_SEARCH raises busy for the whole search. Each forward step
//    stays in ST_SCAN, each backtrack step goes through ST_BACK to ST_SCAN,
//    both bound by the registered read data of the adjacency and stack RAMs.
//  - On success NUM_VERTICES + 1 results follow on consecutive cycles:
//    the circuit vertices from vertex 0, then vertex 0 again with last = 1.
//    On failure a single result with found = 0, vertex = 0, last = 1.
//    Circuit results come from ST_EMIT; a failed scan registers its own.
//  - Each result is on rsp_payload for exactly one cycle with rsp_strobe
//    high; the receiver cannot stall the block.
//  - Synchronous reset clears the adjacency valid flags (all rows read as
//    zero) and the sequencer at once; no clearing sweep is needed.
module hamiltonian_circuit_search
   import hcs_pkg::*;
#(
   parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int VW = $clog2(NUM_VERTICES);
   localparam int DW = VW + 1;
   localparam logic [NUM_VERTICES-1:0] ONE_BIT = NUM_VERTICES'(1);
   localparam logic [DW-1:0] DEPTH_FULL = DW'(NUM_VERTICES);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_BACK = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [DW-1:0]           depth_ff, depth_in;
   logic [NUM_VERTICES-1:0] used_ff, used_in;
   logic [VW-1:0]           cur_ff, cur_in;
   logic [DW-1:0]           from_ff, from_in;
   logic [DW-1:0]           k_ff, k_in;
   logic                    emit_vld_ff, emit_vld_in;
   logic                    found_ff, found_in;
   logic                    last_ff, last_in;

   logic                    accept;
   logic                    adj_wr_en;
   logic [VW-1:0]           adj_rd_addr;
   logic [NUM_VERTICES-1:0] adj_row;

   logic                    path_wr_en;
   logic [VW-1:0]           path_wr_addr;
   logic [VW-1:0]           path_wr_data;
   logic [VW-1:0]           path_rd_addr;
   logic [VW-1:0]           path_rd_data;

   logic [NUM_VERTICES-1:0] start_mask;
   logic [NUM_VERTICES-1:0] cand;
   logic                    has_cand;
   logic [VW-1:0]           cand_idx;

   assign accept    = start && !busy;
   assign adj_wr_en = accept && (req_payload.cmd == CMD_LOAD) &&
                      (int'(req_payload.row_index) < NUM_VERTICES);

   hcs_adj_store #(
      .NUM_VERTICES (NUM_VERTICES)
   ) u_adj_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (adj_wr_en),
      .wr_addr (VW'(req_payload.row_index)),
      .wr_row  (NUM_VERTICES'(req_payload.row_bits)),
      .rd_addr (adj_rd_addr),
      .rd_row  (adj_row)
   );

   hcs_ram #(
      .WIDTH (VW),
      .DEPTH (NUM_VERTICES)
   ) u_path_ram (
      .clock   (clock),
      .wr_en   (path_wr_en),
      .wr_addr (path_wr_addr),
      .wr_data (path_wr_data),
      .rd_en   (1'b1),
      .rd_addr (path_rd_addr),
      .rd_data (path_rd_data)
   );

   // Find the lowest unused successor at or above the resume point.
   always_comb begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
         start_mask[i] = (DW'(i) >= from_ff);
      end
      cand     = adj_row & ~used_ff & start_mask;
      has_cand = |cand;
      cand_idx = '0;
      for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            cand_idx = VW'(i);
         end
      end
   end

   // Sequence the search: advance, backtrack, emit.
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      used_in      = used_ff;
      cur_in       = cur_ff;
      from_in      = from_ff;
      k_in         = k_ff;
      emit_vld_in  = 1'b0;
      found_in     = found_ff;
      last_in      = 1'b0;
      adj_rd_addr  = cur_ff;
      path_wr_en   = 1'b0;
      path_wr_addr = '0;
      path_wr_data = '0;
      path_rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_payload.cmd == CMD_SEARCH)) begin
               depth_in    = DW'(1);
               used_in     = ONE_BIT;
               cur_in      = '0;
               from_in     = DW'(1);
               adj_rd_addr = '0;
               path_wr_en  = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (depth_ff == DEPTH_FULL && adj_row[0]) begin
               // Closing edge found: report the circuit.
               k_in     = '0;
               state_in = ST_EMIT;
            end else if (depth_ff != DEPTH_FULL && has_cand) begin
               // Push the candidate and fetch its row.
               path_wr_en   = 1'b1;
               path_wr_addr = depth_ff[VW-1:0];
               path_wr_data = cand_idx;
               used_in      = used_ff | (ONE_BIT << cand_idx);
               cur_in       = cand_idx;
               depth_in     = depth_ff + DW'(1);
               from_in      = DW'(1);
               adj_rd_addr  = cand_idx;
            end else if (depth_ff <= DW'(1)) begin
               // Nothing left at the first position: no circuit.
               emit_vld_in = 1'b1;
               found_in    = 1'b0;
               last_in     = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               // Pop the tail vertex and fetch the new tail.
               used_in      = used_ff & ~(ONE_BIT << cur_ff);
               from_in      = DW'(cur_ff) + DW'(1);
               depth_in     = depth_ff - DW'(1);
               path_rd_addr = VW'(depth_ff - DW'(2));
               state_in     = ST_BACK;
            end
         end
         ST_BACK: begin
            cur_in      = path_rd_data;
            adj_rd_addr = path_rd_data;
            state_in    = ST_SCAN;
         end
         ST_EMIT: begin
            path_rd_addr = (k_ff == DEPTH_FULL) ? '0 : k_ff[VW-1:0];
            emit_vld_in  = 1'b1;
            found_in     = 1'b1;
            last_in      = (k_ff == DEPTH_FULL);
            k_in         = k_ff + DW'(1);
            if (k_ff == DEPTH_FULL) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold sequencer state; clear control at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         depth_ff    <= '0;
         used_ff     <= '0;
         emit_vld_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         depth_ff    <= depth_in;
         used_ff     <= used_in;
         emit_vld_ff <= emit_vld_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      from_ff  <= from_in;
      k_ff     <= k_in;
      found_ff <= found_in;
   end

   // Drive the result transaction from the path stack read port.
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = emit_vld_ff;
   assign rsp_payload.found  = found_ff;
   assign rsp_payload.vertex = found_ff ? VERTEX_W'(path_rd_data) : '0;
   assign rsp_payload.last   = last_ff;

endmodule

// ===== sv/hcs_checker.sv =====
// Port-level checks for hamiltonian_circuit_search, bound to the top level.
// Depends on hcs_pkg.
module hcs_checker
   import hcs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   // A search transaction keeps the block busy in the next cycle.
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.cmd == CMD_SEARCH |=> busy)
      else $error("search accepted but block not busy");

   // A load transaction leaves the block idle and silent.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.cmd == CMD_LOAD |=> !busy && !rsp_strobe)
      else $error("load caused busy or a result");

   // A not-found result is the final one and carries vertex zero.
   a_fail_form: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.found |-> rsp_payload.last &&
      rsp_payload.vertex == '0)
      else $error("malformed not-found result");

   // Circuit results run on consecutive cycles until the last one.
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last |=> rsp_strobe && rsp_payload.found)
      else $error("gap inside circuit result burst");

   // A circuit closes at vertex zero.
   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.found && rsp_payload.last |->
      rsp_payload.vertex == '0)
      else $error("circuit does not close at vertex zero");

endmodule

bind hamiltonian_circuit_search hcs_checker u_hcs_checker (.*);
